// File: design/hrp_pkg.sv
`default_nettype none

package hrp_pkg;

  // Width of the saturating header byte counter
  localparam int unsigned COUNT_BITS = 16;

  // Configuration reset values
  localparam logic [15:0] LIMIT_RESET = 16'(8 * 1024);
  localparam logic [3:0]  MAJOR_RESET = 4'd1;
  localparam logic [3:0]  MINOR_RESET = 4'd1;

  // Characters of interest
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_H     = 8'h48;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_9     = 8'h39;

  typedef enum logic [1:0] {
    CFG_LIMIT = 2'd0,
    CFG_MAJOR = 2'd1,
    CFG_MINOR = 2'd2
  } cfg_reg_e;

  typedef enum logic [2:0] {
    TK_NONE   = 3'd0,
    TK_METHOD = 3'd1,
    TK_PATH   = 3'd2,
    TK_NAME   = 3'd3,
    TK_VALUE  = 3'd4,
    TK_END    = 3'd5,
    TK_HEAD   = 3'd6,
    TK_ERR    = 3'd7
  } tok_kind_e;

  typedef enum logic [3:0] {
    ERR_NONE        = 4'd0,
    ERR_NO_METHOD   = 4'd1,
    ERR_NO_SLASH    = 4'd2,
    ERR_BAD_LITERAL = 4'd3,
    ERR_BAD_DIGIT   = 4'd4,
    ERR_VERSION     = 4'd5,
    ERR_NO_EOL      = 4'd6,
    ERR_NO_LF       = 4'd7,
    ERR_SP_BEFORE   = 4'd8,
    ERR_SP_AFTER    = 4'd9,
    ERR_TOO_BIG     = 4'd10
  } err_e;

  // Request line states, one-hot
  typedef enum logic [17:0] {
    LS_NOT_STARTED = 18'h00001,
    LS_METHOD      = 18'h00002,
    LS_SP_PATH     = 18'h00004,
    LS_PATH        = 18'h00008,
    LS_LIT_H       = 18'h00010,
    LS_LIT_T1      = 18'h00020,
    LS_LIT_T2      = 18'h00040,
    LS_LIT_P       = 18'h00080,
    LS_LIT_SL      = 18'h00100,
    LS_MAJOR       = 18'h00200,
    LS_DOT         = 18'h00400,
    LS_MINOR       = 18'h00800,
    LS_EOL         = 18'h01000,
    LS_LINE_CR     = 18'h02000,
    LS_LINE_LF     = 18'h04000,
    LS_HEAD_CR     = 18'h08000,
    LS_FIELDS      = 18'h10000,
    LS_DONE        = 18'h20000
  } line_state_e;

  // Header field states, one-hot
  typedef enum logic [8:0] {
    FS_NAME      = 9'h001,
    FS_COLON     = 9'h002,
    FS_SP_BEFORE = 9'h004,
    FS_VALUE     = 9'h008,
    FS_SP_AFTER  = 9'h010,
    FS_CR        = 9'h020,
    FS_LF        = 9'h040,
    FS_CR2       = 9'h080,
    FS_END       = 9'h100
  } field_state_e;

  // One result as it travels to the output
  typedef struct packed {
    tok_kind_e   kind;
    logic [7:0]  tbyte;
    err_e        err;
    logic        last;
  } res_t;

  // Results produced by one byte, written into the result queue together
  typedef struct packed {
    logic [1:0]  num;
    res_t        r0;
    res_t        r1;
  } push_t;

endpackage

`default_nettype wire

// File: design/hrp_if.sv
`default_nettype none

// Request byte channel
interface hrp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       new_request;

  modport source (output valid, output data_byte, output new_request, input ready);
  modport sink   (input valid, input data_byte, input new_request, output ready);
endinterface

// Token result channel
interface hrp_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] token_kind;
  logic [7:0] token_byte;
  logic [3:0] error_code;
  logic       last;

  modport source (output valid, output token_kind, output token_byte, output error_code,
                  output last, input ready);
  modport sink   (input valid, input token_kind, input token_byte, input error_code,
                  input last, output ready);
endinterface

// Configuration write channel
interface hrp_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: design/hrp_core.sv
`default_nettype none

module hrp_core #(
  parameter int unsigned CountBits = hrp_pkg::COUNT_BITS
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  hrp_in_if.sink             in_ch,
  input  wire logic [15:0]   limit_i,
  input  wire logic [3:0]    major_i,
  input  wire logic [3:0]    minor_i,
  input  wire logic          room_i,
  output hrp_pkg::push_t     push_o
);

  localparam int unsigned CmpW = (CountBits > 16) ? CountBits : 16;

  // Input register
  logic                  s_valid_q;
  logic [7:0]            s_byte_q;
  logic                  s_new_q;
  logic                  step;

  // Parser state
  hrp_pkg::line_state_e  ls_q, ls_d, ls_cur;
  hrp_pkg::field_state_e fs_q, fs_d, fs_cur, fs_hb;
  logic [CountBits-1:0]  cnt_q, cnt_d, cnt_cur, cnt_inc;
  logic                  ne_q, ne_d, ne_cur;
  logic [3:0]            maj_q, maj_d, maj_cur;
  logic [3:0]            min_q, min_d, min_cur;
  logic                  fail_q, fail_d, fail_cur;
  hrp_pkg::err_e         err_q, err_d, err_cur;

  // Step scratch
  logic [7:0]            c;
  logic                  is_digit;
  logic                  hb;
  logic                  count_it;
  logic [1:0]            rn;
  hrp_pkg::tok_kind_e    rk0, rk1;
  logic [7:0]            rb0, rb1;

  assign step        = s_valid_q & room_i;
  assign in_ch.ready = ~s_valid_q | room_i;

  // Hold the accepted byte until the queue has room for its results
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid_q <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      s_valid_q <= 1'b1;
    end else if (step) begin
      s_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ch.valid && in_ch.ready) begin
      s_byte_q <= in_ch.data_byte;
      s_new_q  <= in_ch.new_request;
    end
  end

  // Start from cleared state when the byte opens a new request
  always_comb begin
    c = s_byte_q;
    if (s_new_q) begin
      ls_cur   = hrp_pkg::LS_NOT_STARTED;
      fs_cur   = hrp_pkg::FS_NAME;
      cnt_cur  = '0;
      ne_cur   = 1'b1;
      maj_cur  = 4'd0;
      min_cur  = 4'd0;
      fail_cur = 1'b0;
      err_cur  = hrp_pkg::ERR_NONE;
    end else begin
      ls_cur   = ls_q;
      fs_cur   = fs_q;
      cnt_cur  = cnt_q;
      ne_cur   = ne_q;
      maj_cur  = maj_q;
      min_cur  = min_q;
      fail_cur = fail_q;
      err_cur  = err_q;
    end
  end

  assign is_digit = (c >= hrp_pkg::CH_0) && (c <= hrp_pkg::CH_9);
  assign cnt_inc  = (&cnt_cur) ? cnt_cur : cnt_cur + CountBits'(1);

  // Step the request line and header field machines for one byte
  always_comb begin
    ls_d     = ls_cur;
    fs_d     = fs_cur;
    fs_hb    = fs_cur;
    cnt_d    = cnt_cur;
    ne_d     = ne_cur;
    maj_d    = maj_cur;
    min_d    = min_cur;
    fail_d   = fail_cur;
    err_d    = err_cur;
    hb       = 1'b0;
    count_it = 1'b0;
    rn       = 2'd0;
    rk0      = hrp_pkg::TK_NONE;
    rk1      = hrp_pkg::TK_NONE;
    rb0      = c;
    rb1      = c;

    if (!fail_cur) begin
      unique case (ls_cur)
        hrp_pkg::LS_NOT_STARTED: begin
          if (c == hrp_pkg::CH_CR || c == hrp_pkg::CH_LF) begin
            ls_d = ls_cur;
          end else if (c == hrp_pkg::CH_SP) begin
            fail_d = 1'b1;
            err_d  = hrp_pkg::ERR_NO_METHOD;
          end else begin
            ls_d = hrp_pkg::LS_METHOD;
            rn   = 2'd1;
            rk0  = hrp_pkg::TK_METHOD;
          end
        end
        hrp_pkg::LS_METHOD: begin
          rn = 2'd1;
          if (c == hrp_pkg::CH_SP) begin
            ls_d = hrp_pkg::LS_SP_PATH;
            rk0  = hrp_pkg::TK_END;
          end else begin
            rk0 = hrp_pkg::TK_METHOD;
          end
        end
        hrp_pkg::LS_SP_PATH: begin
          if (c == hrp_pkg::CH_SP) begin
            ls_d = ls_cur;
          end else if (c != hrp_pkg::CH_SLASH) begin
            fail_d = 1'b1;
            err_d  = hrp_pkg::ERR_NO_SLASH;
          end else begin
            ls_d = hrp_pkg::LS_PATH;
            rn   = 2'd1;
            rk0  = hrp_pkg::TK_PATH;
          end
        end
        hrp_pkg::LS_PATH: begin
          rn = 2'd1;
          if (c == hrp_pkg::CH_SP) begin
            ls_d = hrp_pkg::LS_LIT_H;
            rk0  = hrp_pkg::TK_END;
          end else begin
            rk0 = hrp_pkg::TK_PATH;
          end
        end
        hrp_pkg::LS_LIT_H: begin
          if (c == hrp_pkg::CH_H) ls_d = hrp_pkg::LS_LIT_T1;
          else begin
            fail_d = 1'b1;
            err_d  = hrp_pkg::ERR_BAD_LITERAL;
          end
        end
        hrp_pkg::LS_LIT_T1: begin
          if (c == hrp_pkg::CH_T) ls_d = hrp_pkg::LS_LIT_T2;
          else begin
            fail_d = 1'b1;
            err_d  = hrp_pkg::ERR_BAD_LITERAL;
          end
        end
        hrp_pkg::LS_LIT_T2: begin
          if (c == hrp_pkg::CH_T) ls_d = hrp_pkg::LS_LIT_P;
          else begin
            fail_d = 1'b1;
            err_d  = hrp_pkg::ERR_BAD_LITERAL;
          end
        end
        hrp_pkg::LS_LIT_P: begin
          if (c == hrp_pkg::CH_P) ls_d = hrp_pkg::LS_LIT_SL;
          else begin
            fail_d = 1'b1;
            err_d  = hrp_pkg::ERR_BAD_LITERAL;
          end
        end
        hrp_pkg::LS_LIT_SL: begin
          if (c == hrp_pkg::CH_SLASH) ls_d = hrp_pkg::LS_MAJOR;
          else begin
            fail_d = 1'b1;
            err_d  = hrp_pkg::ERR_BAD_LITERAL;
          end
        end
        hrp_pkg::LS_MAJOR: begin
          if (!is_digit) begin
            fail_d = 1'b1;
            err_d  = hrp_pkg::ERR_BAD_DIGIT;
          end else begin
            maj_d = c[3:0];
            ls_d  = hrp_pkg::LS_DOT;
          end
        end
        hrp_pkg::LS_DOT: begin
          if (c == hrp_pkg::CH_DOT) ls_d = hrp_pkg::LS_MINOR;
          else begin
            fail_d = 1'b1;
            err_d  = hrp_pkg::ERR_BAD_LITERAL;
          end
        end
        hrp_pkg::LS_MINOR: begin
          if (!is_digit) begin
            fail_d = 1'b1;
            err_d  = hrp_pkg::ERR_BAD_DIGIT;
          end else begin
            min_d = c[3:0];
            ls_d  = hrp_pkg::LS_EOL;
          end
        end
        hrp_pkg::LS_EOL: begin
          // Version is checked ahead of the line end
          if (maj_cur != major_i || min_cur != minor_i) begin
            fail_d = 1'b1;
            err_d  = hrp_pkg::ERR_VERSION;
          end else if (c == hrp_pkg::CH_CR) begin
            ls_d = hrp_pkg::LS_LINE_CR;
          end else if (c == hrp_pkg::CH_LF) begin
            ls_d = hrp_pkg::LS_LINE_LF;
          end else begin
            fail_d = 1'b1;
            err_d  = hrp_pkg::ERR_NO_EOL;
          end
        end
        hrp_pkg::LS_LINE_CR: begin
          if (c == hrp_pkg::CH_LF) ls_d = hrp_pkg::LS_LINE_LF;
          else begin
            fail_d = 1'b1;
            err_d  = hrp_pkg::ERR_NO_LF;
          end
        end
        hrp_pkg::LS_LINE_LF: begin
          if (c == hrp_pkg::CH_CR) begin
            ls_d = hrp_pkg::LS_HEAD_CR;
          end else if (c == hrp_pkg::CH_LF) begin
            ls_d = hrp_pkg::LS_DONE;
            rn   = 2'd1;
            rk0  = hrp_pkg::TK_HEAD;
          end else begin
            // First header starts: handled as a byte after a line feed
            ls_d  = hrp_pkg::LS_FIELDS;
            fs_hb = hrp_pkg::FS_LF;
            hb    = 1'b1;
          end
        end
        hrp_pkg::LS_HEAD_CR: begin
          ls_d = hrp_pkg::LS_DONE;
          rn   = 2'd1;
          rk0  = hrp_pkg::TK_HEAD;
        end
        hrp_pkg::LS_FIELDS: begin
          hb = 1'b1;
        end
        default: begin
          ls_d = ls_cur;
        end
      endcase
    end

    // Header field byte
    if (hb) begin
      unique case (fs_hb)
        hrp_pkg::FS_NAME: begin
          if (c == hrp_pkg::CH_SP) begin
            fail_d = 1'b1;
            err_d  = ne_cur ? hrp_pkg::ERR_SP_BEFORE : hrp_pkg::ERR_SP_AFTER;
          end else begin
            count_it = 1'b1;
            rn       = 2'd1;
            if (c == hrp_pkg::CH_COLON) begin
              fs_d = hrp_pkg::FS_COLON;
              rk0  = hrp_pkg::TK_END;
            end else begin
              ne_d = 1'b0;
              rk0  = hrp_pkg::TK_NAME;
            end
          end
        end
        hrp_pkg::FS_COLON, hrp_pkg::FS_SP_BEFORE: begin
          count_it = 1'b1;
          if (c == hrp_pkg::CH_SP) begin
            fs_d = hrp_pkg::FS_SP_BEFORE;
          end else begin
            fs_d = hrp_pkg::FS_VALUE;
            rn   = 2'd1;
            rk0  = hrp_pkg::TK_VALUE;
          end
        end
        hrp_pkg::FS_VALUE, hrp_pkg::FS_SP_AFTER: begin
          count_it = 1'b1;
          if (c == hrp_pkg::CH_SP) begin
            fs_d = hrp_pkg::FS_SP_AFTER;
          end else if (c == hrp_pkg::CH_CR || c == hrp_pkg::CH_LF) begin
            fs_d = (c == hrp_pkg::CH_CR) ? hrp_pkg::FS_CR : hrp_pkg::FS_LF;
            ne_d = 1'b1;
            rn   = 2'd1;
            rk0  = hrp_pkg::TK_END;
          end else if (fs_hb == hrp_pkg::FS_SP_AFTER) begin
            // Fold the run of spaces into one space ahead of this byte
            fs_d = hrp_pkg::FS_VALUE;
            rn   = 2'd2;
            rk0  = hrp_pkg::TK_VALUE;
            rb0  = hrp_pkg::CH_SP;
            rk1  = hrp_pkg::TK_VALUE;
          end else begin
            fs_d = hrp_pkg::FS_VALUE;
            rn   = 2'd1;
            rk0  = hrp_pkg::TK_VALUE;
          end
        end
        hrp_pkg::FS_CR: begin
          if (c != hrp_pkg::CH_LF) begin
            fail_d = 1'b1;
            err_d  = hrp_pkg::ERR_NO_LF;
          end else begin
            fs_d     = hrp_pkg::FS_LF;
            count_it = 1'b1;
          end
        end
        hrp_pkg::FS_LF: begin
          count_it = 1'b1;
          if (c == hrp_pkg::CH_CR) begin
            fs_d = hrp_pkg::FS_CR2;
          end else if (c == hrp_pkg::CH_LF) begin
            fs_d = hrp_pkg::FS_END;
            ls_d = hrp_pkg::LS_DONE;
            rn   = 2'd1;
            rk0  = hrp_pkg::TK_HEAD;
          end else begin
            fs_d = hrp_pkg::FS_NAME;
            ne_d = 1'b0;
            rn   = 2'd1;
            rk0  = hrp_pkg::TK_NAME;
          end
        end
        hrp_pkg::FS_CR2: begin
          if (c != hrp_pkg::CH_LF) begin
            fail_d = 1'b1;
            err_d  = hrp_pkg::ERR_NO_LF;
          end else begin
            count_it = 1'b1;
            fs_d     = hrp_pkg::FS_END;
            ls_d     = hrp_pkg::LS_DONE;
            rn       = 2'd1;
            rk0      = hrp_pkg::TK_HEAD;
          end
        end
        default: begin
          fs_d = fs_cur;
        end
      endcase

      // Count the header byte and enforce the limit
      if (count_it) begin
        cnt_d = cnt_inc;
        if (CmpW'(cnt_inc) >= CmpW'(limit_i)) begin
          fail_d = 1'b1;
          err_d  = hrp_pkg::ERR_TOO_BIG;
        end
      end
    end
  end

  // Pack the results of this byte for the queue
  always_comb begin
    push_o = '0;
    if (fail_d) begin
      push_o.num = 2'd1;
      push_o.r0  = '{kind: hrp_pkg::TK_ERR, tbyte: c, err: err_d, last: 1'b1};
    end else if (rn == 2'd2) begin
      push_o.num = 2'd2;
      push_o.r0  = '{kind: rk0, tbyte: rb0, err: hrp_pkg::ERR_NONE, last: 1'b0};
      push_o.r1  = '{kind: rk1, tbyte: rb1, err: hrp_pkg::ERR_NONE, last: 1'b1};
    end else begin
      push_o.num = 2'd1;
      push_o.r0  = '{kind: rk0, tbyte: rb0, err: hrp_pkg::ERR_NONE, last: 1'b1};
    end
    if (!step) begin
      push_o.num = 2'd0;
    end
  end

  // Advance parser state on every stepped byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ls_q   <= hrp_pkg::LS_NOT_STARTED;
      fs_q   <= hrp_pkg::FS_NAME;
      cnt_q  <= '0;
      ne_q   <= 1'b1;
      maj_q  <= 4'd0;
      min_q  <= 4'd0;
      fail_q <= 1'b0;
      err_q  <= hrp_pkg::ERR_NONE;
    end else if (step) begin
      ls_q   <= ls_d;
      fs_q   <= fs_d;
      cnt_q  <= cnt_d;
      ne_q   <= ne_d;
      maj_q  <= maj_d;
      min_q  <= min_d;
      fail_q <= fail_d;
      err_q  <= err_d;
    end
  end

endmodule

`default_nettype wire

// File: design/hrp_res_fifo.sv
`default_nettype none

module hrp_res_fifo (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  hrp_pkg::push_t     push_i,
  output logic               room_o,
  hrp_out_if.source          out_ch
);

  localparam int unsigned Depth = 4;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  hrp_pkg::res_t   mem_q [Depth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            pop;
  hrp_pkg::res_t   head;

  // Room for a full pair of results
  assign room_o = (cnt_q <= CntW'(Depth - 2));
  assign pop    = out_ch.valid & out_ch.ready;
  assign head   = mem_q[rd_q];

  assign out_ch.valid      = (cnt_q != '0);
  assign out_ch.token_kind = head.kind;
  assign out_ch.token_byte = head.tbyte;
  assign out_ch.error_code = head.err;
  assign out_ch.last       = head.last;

  // Write one or two results per stepped byte
  always_ff @(posedge clk_i) begin
    if (push_i.num != 2'd0) begin
      mem_q[wr_q] <= push_i.r0;
    end
    if (push_i.num == 2'd2) begin
      mem_q[wr_q + PtrW'(1)] <= push_i.r1;
    end
  end

  always_comb begin
    wr_d  = wr_q + PtrW'(push_i.num);
    rd_d  = pop ? rd_q + PtrW'(1) : rd_q;
    cnt_d = cnt_q + CntW'(push_i.num) - CntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  a_push_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.num != 2'd0 |-> cnt_q <= CntW'(Depth - 2))
    else $error("result pushed without room");

  a_never_over: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth))
    else $error("result queue overfilled");

  a_pair_marked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.num == 2'd2 |-> !push_i.r0.last && push_i.r1.last)
    else $error("folded pair marked wrongly");

  a_pair_whole: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && !out_ch.last |=> cnt_q != '0)
    else $error("second result of a pair missing");

endmodule

`default_nettype wire

// File: design/http_request_head_parser.sv
`default_nettype none

// Channel   Dir  Payload                                         Role
// in_ch     in   data_byte[8], new_request[1]                    request bytes
// out_ch    out  token_kind[3], token_byte[8], error_code[4],    token results
//                last[1]
// cfg_ch    in   index[2], data[16]                              register writes
//
// One byte is accepted per cycle while the queue has room. A byte that closes
// a run of folded spaces yields two results; others yield one. Each byte
// passes the input register, then the parser step writes its results into
// the four-entry result queue, whose head drives out_ch. Input stalls only
// when the result queue cannot take a pair of results.
// Reset clears all parser state and loads the register defaults; no clear
// pass is needed. Configuration writes are taken every cycle.
module http_request_head_parser #(
  parameter int unsigned CountBits = hrp_pkg::COUNT_BITS
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  hrp_in_if.sink    in_ch,
  hrp_out_if.source out_ch,
  hrp_cfg_if.sink   cfg_ch
);

  logic [15:0]    limit_q;
  logic [3:0]     major_q;
  logic [3:0]     minor_q;
  logic           room;
  hrp_pkg::push_t push;

  assign cfg_ch.ready = 1'b1;

  // Configuration registers; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= hrp_pkg::LIMIT_RESET;
      major_q <= hrp_pkg::MAJOR_RESET;
      minor_q <= hrp_pkg::MINOR_RESET;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      unique case (cfg_ch.index)
        hrp_pkg::CFG_LIMIT: limit_q <= cfg_ch.data;
        hrp_pkg::CFG_MAJOR: major_q <= cfg_ch.data[3:0];
        hrp_pkg::CFG_MINOR: minor_q <= cfg_ch.data[3:0];
        default: ;
      endcase
    end
  end

  hrp_core #(
    .CountBits(CountBits)
  ) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_ch   (in_ch),
    .limit_i (limit_q),
    .major_i (major_q),
    .minor_i (minor_q),
    .room_i  (room),
    .push_o  (push)
  );

  hrp_res_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .room_o (room),
    .out_ch (out_ch)
  );

endmodule

`default_nettype wire
